@@ rtl/core/hf2srgb_pkg.sv @@
// Shared types, constants and the build-time code threshold table for half_float_to_srgb8.
`timescale 1ns / 1ps
`default_nettype none

package hf2srgb_pkg;

   localparam int CODE_W = 8;
   localparam int KEY_W  = 15;
   localparam int CODES  = 1 << CODE_W;

   localparam logic [4:0]       EXP_MAX  = 5'h1f;
   localparam logic [KEY_W-1:0] ONE_KEY  = 15'h3c00;   // bit pattern of 1.0
   localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

   // Item as it travels down the pipeline.
   typedef struct packed {
      logic                 valid;
      logic                 force_zero;   // NaN or sign set
      logic                 force_max;    // >= 1.0 or +inf
      logic [KEY_W-1:0]     key;          // magnitude bits of the half
      logic [CODE_W-1:0]    code;         // code bits settled so far
   } stage_type;

   // True when the positive half h (below 1.0) encodes to a code of at least k.
   // Exact: linear segment by integer compare, power segment by
   // M^5 * 10761^12 >= (40k + 541)^12 * 2^120.
   function automatic logic reaches_code(logic [KEY_W-1:0] h, int k);
      logic [4:0]   ex;
      logic [9:0]   man;
      logic [23:0]  m;
      logic [63:0]  lin_l;
      logic [63:0]  lin_r;
      logic [15:0]  n;
      logic [319:0] lhs;
      logic [319:0] rhs;
      ex  = h[14:10];
      man = h[9:0];
      if (ex == 5'd0) begin
         m = {14'd0, man};
      end else begin
         m = 24'({13'd0, 1'b1, man} << (ex - 5'd1));
      end
      lin_l = 64'(m) * 64'd10000000;
      lin_r = 64'd31308 << 24;
      if (lin_l <= lin_r) begin
         return (64'd32946 * 64'(m) + 64'd83886080) >= (64'(k) * 64'd167772160);
      end
      n   = 16'(40 * k + 541);
      lhs = 320'd1;
      rhs = 320'd1;
      for (int i = 0; i < 5; i++) begin
         lhs = lhs * 320'(m);
         rhs = rhs << 24;
      end
      for (int i = 0; i < 12; i++) begin
         lhs = lhs * 320'd10761;
         rhs = rhs * 320'(n);
      end
      return lhs >= rhs;
   endfunction

   // Entry k: smallest magnitude pattern whose code is at least k
   // (ONE_KEY when no value below 1.0 reaches it). Entry 0 is zero.
   function automatic logic [CODES-1:0][KEY_W-1:0] build_thresholds();
      logic [CODES-1:0][KEY_W-1:0] t;
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] hi;
      logic [KEY_W-1:0] mid;
      t[0] = '0;
      for (int k = 1; k < CODES; k++) begin
         lo = 15'd1;
         hi = ONE_KEY;
         for (int i = 0; i < KEY_W; i++) begin
            if (lo < hi) begin
               mid = KEY_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
               if (reaches_code(mid, k)) begin
                  hi = mid;
               end else begin
                  lo = mid + 15'd1;
               end
            end
         end
         t[k] = lo;
      end
      return t;
   endfunction

   localparam logic [CODES-1:0][KEY_W-1:0] THRESHOLD = build_thresholds();

endpackage

`default_nettype wire

@@ rtl/core/hf2srgb_classify.sv @@
// Input register stage: splits the half and flags the special cases.
`timescale 1ns / 1ps
`default_nettype none

module hf2srgb_classify (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [15:0]           req_half_value,
   output hf2srgb_pkg::stage_type     stage_out
);

   hf2srgb_pkg::stage_type stage_in;
   hf2srgb_pkg::stage_type stage_ff;
   logic                   is_nan;

   always_comb begin
      is_nan = (req_half_value[14:10] == hf2srgb_pkg::EXP_MAX) &&
               (req_half_value[9:0] != 10'd0);
      stage_in.valid      = start;
      stage_in.force_zero = is_nan || req_half_value[15];
      stage_in.force_max  = !is_nan && !req_half_value[15] &&
                            (req_half_value[14:0] >= hf2srgb_pkg::ONE_KEY);
      stage_in.key        = req_half_value[14:0];
      stage_in.code       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.force_zero <= stage_in.force_zero;
      stage_ff.force_max  <= stage_in.force_max;
      stage_ff.key        <= stage_in.key;
      stage_ff.code       <= stage_in.code;
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

@@ rtl/core/hf2srgb_search_stage.sv @@
// One bisection step of the code search: settles one code bit against the threshold table.
`timescale 1ns / 1ps
`default_nettype none

module hf2srgb_search_stage #(
   parameter int STEP_BIT = hf2srgb_pkg::CODE_W - 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  hf2srgb_pkg::stage_type stage_in,
   output hf2srgb_pkg::stage_type stage_out
);

   hf2srgb_pkg::stage_type            next_in;
   hf2srgb_pkg::stage_type            stage_ff;
   logic [hf2srgb_pkg::CODE_W-1:0]    trial;

   always_comb begin
      trial   = stage_in.code | (hf2srgb_pkg::CODE_W'(1) << STEP_BIT);
      next_in = stage_in;
      if (stage_in.key >= hf2srgb_pkg::THRESHOLD[trial]) begin
         next_in.code = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= next_in.valid;
      end
      stage_ff.force_zero <= next_in.force_zero;
      stage_ff.force_max  <= next_in.force_max;
      stage_ff.key        <= next_in.key;
      stage_ff.code       <= next_in.code;
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

@@ rtl/core/half_float_to_srgb8.sv @@
// Top level: half-float linear light to 8-bit sRGB code, fully pipelined.
`timescale 1ns / 1ps
`default_nettype none

// Converts one IEEE half-precision linear value to its 8-bit sRGB code.
// A transaction is taken on every clock edge with start high; busy is held
// low, so one sample per cycle is sustained. The code appears on
// rsp_srgb_code with rsp_valid high for exactly one cycle, once the sample
// has passed the input register, eight search steps and the output
// register. The receiver cannot stall the pipeline: it must take each
// result in the cycle it is shown. The search is an eight-step
// bisection over a 256-entry threshold table, one code bit per stage.
// Negative inputs, zeros and NaNs give 0; 1.0 and above, and +inf, give 255;
// subnormals are handled with their true value. Ties round up.

module half_float_to_srgb8 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [15:0] req_half_value,
   output      logic        rsp_valid,
   output      logic [7:0]  rsp_srgb_code
);

   localparam int STEPS = hf2srgb_pkg::CODE_W;

   // pipe[0] leaves the input stage; pipe[i+1] leaves search step i
   hf2srgb_pkg::stage_type pipe [STEPS+1];

   logic                          rsp_valid_in;
   logic                          rsp_valid_ff;
   logic [hf2srgb_pkg::CODE_W-1:0] rsp_code_in;
   logic [hf2srgb_pkg::CODE_W-1:0] rsp_code_ff;

   // never backs up: a new transaction can enter every cycle
   assign busy = 1'b0;

   hf2srgb_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_half_value (req_half_value),
      .stage_out      (pipe[0])
   );

   // MSB first: each step tries setting one more code bit
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      hf2srgb_search_stage #(
         .STEP_BIT (STEPS - 1 - g)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (pipe[g]),
         .stage_out (pipe[g+1])
      );
   end

   // special cases override the searched code
   always_comb begin
      rsp_valid_in = pipe[STEPS].valid;
      priority if (pipe[STEPS].force_zero) begin
         rsp_code_in = '0;
      end else if (pipe[STEPS].force_max) begin
         rsp_code_in = hf2srgb_pkg::CODE_MAX;
      end else begin
         rsp_code_in = pipe[STEPS].code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_srgb_code = rsp_code_ff;

endmodule

`default_nettype wire

@@ test/srgb_code_checker.sv @@
// Checker for half_float_to_srgb8: predicts each sRGB code and compares it with the result.
`timescale 1ns / 1ps

module srgb_code_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [15:0] req_half_value,
   input  wire logic        rsp_valid,
   input  wire logic [7:0]  rsp_srgb_code,
   output int               failures,
   output int               pending
);

   typedef struct packed {
      logic [15:0] half_value;
      logic [7:0]  srgb_code;
   } code_entry_type;

   code_entry_type expected_codes [$];

   // Power segment: v^5 >= ((40k + 541) / 10761)^12, scaled by 2^120 * 10761^12 on both sides.
   function automatic logic power_reaches_code(logic [319:0] scaled_m5, int k);
      logic [319:0] bound;
      bound = 320'd1;
      for (int i = 0; i < 12; i++) begin
         bound = bound * 320'(40 * k + 541);
      end
      bound = bound << 120;
      return scaled_m5 >= bound;
   endfunction

   function automatic logic [7:0] predict_srgb_code(logic [15:0] half_value);
      logic         sign_bit;
      logic [4:0]   expo;
      logic [9:0]   frac;
      logic [23:0]  m;
      logic [63:0]  lin_code;
      logic [319:0] scaled_m5;
      logic [7:0]   code;
      logic [7:0]   trial;
      sign_bit = half_value[15];
      expo     = half_value[14:10];
      frac     = half_value[9:0];
      if (expo == 5'h1f && frac != 10'd0) return 8'd0;   // NaN of either sign
      if (sign_bit) return 8'd0;                          // negatives, -0, -inf
      if (expo >= 5'd15) return 8'd255;                   // 1.0 and up, +inf
      if (expo == 5'd0) begin
         if (frac == 10'd0) return 8'd0;
         m = {14'd0, frac};                               // subnormal: exact M
      end else begin
         m = 24'({13'd0, 1'b1, frac} << (expo - 5'd1));
      end
      // linear segment up to 0.0031308
      if (64'(m) * 64'd10000000 <= (64'd31308 << 24)) begin
         lin_code = (64'd32946 * 64'(m) + 64'd83886080) / 64'd167772160;
         return (lin_code > 64'd255) ? 8'd255 : lin_code[7:0];
      end
      scaled_m5 = 320'd1;
      for (int i = 0; i < 5; i++) begin
         scaled_m5 = scaled_m5 * 320'(m);
      end
      for (int i = 0; i < 12; i++) begin
         scaled_m5 = scaled_m5 * 320'd10761;
      end
      // largest code whose lower boundary is reached, MSB first
      code = 8'd0;
      for (int b = 7; b >= 0; b--) begin
         trial = code | (8'd1 << b);
         if (power_reaches_code(scaled_m5, int'(trial))) begin
            code = trial;
         end
      end
      return code;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: srgb check: %s", $time, what);
      failures++;
   endtask

   initial begin
      failures = 0;
      pending  = 0;
   end

   always @(posedge clock) begin
      code_entry_type oldest;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("unexpected result code %0d", rsp_srgb_code));
            end else begin
               oldest = expected_codes.pop_front();
               if (rsp_srgb_code !== oldest.srgb_code) begin
                  report_mismatch($sformatf("half %h: code %0d, want %0d",
                                            oldest.half_value, rsp_srgb_code,
                                            oldest.srgb_code));
               end
            end
         end
         if (start && !busy) begin
            expected_codes.push_back({req_half_value, predict_srgb_code(req_half_value)});
         end
      end
      pending <= expected_codes.size();
   end

endmodule

@@ test/tb_half_float_to_srgb8.sv @@
// Testbench top for half_float_to_srgb8: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps

module tb_half_float_to_srgb8;

   localparam int RANDOM_ITEMS  = 1250;
   localparam int DRAIN_CYCLES  = 30;    // pipeline is 10 deep; allow margin
   localparam int CORNER_COUNT  = 24;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_half_value;
   logic        rsp_valid;
   logic [7:0]  rsp_srgb_code;
   int          failures;
   int          pending;

   half_float_to_srgb8 dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_half_value (req_half_value),
      .rsp_valid      (rsp_valid),
      .rsp_srgb_code  (rsp_srgb_code)
   );

   // Watches both channels, predicts and compares; only counts come back.
   srgb_code_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_half_value (req_half_value),
      .rsp_valid      (rsp_valid),
      .rsp_srgb_code  (rsp_srgb_code),
      .failures       (failures),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Present one transaction and hold it until the edge that takes it.
   // busy is read right after the edge, so it is the value the DUT saw.
   task automatic send_half(input logic [15:0] value);
      start          <= 1'b1;
      req_half_value <= value;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a number of cycles; the data lines carry junk meanwhile.
   task automatic pause_sender(input int cycles);
      start          <= 1'b0;
      req_half_value <= 16'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every outstanding transaction has produced its code.
   // pending is registered, so step once before looking at it.
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Random half, weighted toward the curve (positive, below 1.0).
   function automatic logic [15:0] pick_half();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 16'($urandom_range(16'h0001, 16'h3bff));
      if (pick < 65) return 16'($urandom_range(16'h0000, 16'h1c00));   // linear region and a little beyond, subnormals
      if (pick < 75) return 16'($urandom_range(16'h3c00, 16'h7fff));   // >= 1.0, inf, NaN
      return 16'($urandom);                                             // anything, sign included
   endfunction

   initial begin
      logic [15:0] corner_values [0:CORNER_COUNT-1];
      int          sent;
      int          burst_len;
      int          gap;
      logic        drained_mid;

      corner_values = '{
         16'h0000,   // +0
         16'h8000,   // -0
         16'h0001,   // smallest subnormal
         16'h0200,   // mid subnormal
         16'h03ff,   // largest subnormal
         16'h0400,   // smallest normal
         16'h1a69,   // just below the linear/power split
         16'h1a6a,   // just above the split
         16'h2000,
         16'h3000,
         16'h3800,   // 0.5
         16'h3bff,   // largest value below 1.0
         16'h3c00,   // 1.0
         16'h3c01,
         16'h7bff,   // largest finite
         16'h7c00,   // +inf
         16'hfc00,   // -inf
         16'h7c01,   // NaN, low payload
         16'h7e00,   // quiet NaN
         16'h7fff,   // NaN, all payload bits
         16'hfe00,   // negative NaN
         16'hbc00,   // -1.0
         16'h8001,   // negative subnormal
         16'hbbff    // negative, just above -1.0
      };

      // every input driven from time zero; synchronous reset held at the start
      reset          = 1'b1;
      start          = 1'b0;
      req_half_value = 16'h0000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners, back to back
      for (int i = 0; i < CORNER_COUNT; i++) begin
         send_half(corner_values[i]);
      end
      wait_for_drain();

      // random bursts with random gaps; zero gaps give stretches at full rate
      sent        = 0;
      drained_mid = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 24);
         for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
            send_half(pick_half());
            sent++;
         end
         if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
            drained_mid = 1'b1;
            wait_for_drain();
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               pause_sender(gap);
            end
         end
      end

      // let the pipeline empty, then keep watching to catch stray strobes
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && pending == 0) begin
         $display("[half_float_to_srgb8] OK");
      end else begin
         $display("[half_float_to_srgb8] ERROR");
      end
      $finish;
   end

   // Watchdog: the whole run needs a few tens of microseconds.
   initial begin
      #2_000_000;
      $display("[half_float_to_srgb8] ERROR");
      $finish;
   end

endmodule

@@ half_float_to_srgb8.f @@
rtl/core/hf2srgb_pkg.sv
rtl/core/hf2srgb_classify.sv
rtl/core/hf2srgb_search_stage.sv
rtl/core/half_float_to_srgb8.sv
test/srgb_code_checker.sv
test/tb_half_float_to_srgb8.sv
